// File: sv/bis_pkg.sv
// Package for the binary insertion sort engine: sizes, beat types and states.
// It depends on nothing; every other file in the folder imports it.
`default_nettype none
package bis_pkg;

    localparam int MAX_ITEMS = 16;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int DATA_W    = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     final_res;
        logic                     overflowed;
    } out_item_t;

    typedef struct packed {
        logic                     en;
        logic [IDX_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } ins_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } bis_state_t;

endpackage
`default_nettype wire

// File: sv/bis_store.sv
// Sorted store of the sort engine: a row of registers with a parallel shift-insert
// and one read port. It depends on bis_pkg.
`default_nettype none
module bis_store
    import bis_pkg::*;
(
    input  wire logic                     clk,
    input  wire ins_cmd_t                 ins,
    input  wire logic [IDX_W-1:0]         rd_addr,
    output logic signed [DATA_W-1:0]      rd_data
);

    logic signed [DATA_W-1:0] store_reg [MAX_ITEMS];

    always_ff @(posedge clk)
    begin
        if (ins.en && ins.pos == '0)
        begin
            store_reg[0] <= ins.value;
        end
    end

    for (genvar k = 1; k < MAX_ITEMS; k++)
    begin : g_entry
        always_ff @(posedge clk)
        begin
            if (ins.en)
            begin
                if (IDX_W'(k) == ins.pos)
                begin
                    store_reg[k] <= ins.value;
                end
                else if (IDX_W'(k) > ins.pos)
                begin
                    store_reg[k] <= store_reg[k-1];
                end
            end
        end
    end

    assign rd_data = store_reg[rd_addr];

endmodule
`default_nettype wire

// File: sv/bis_ctrl.sv
// Sequencer of the sort engine: binary search with one shared comparator,
// insert command, and the emit sweep over the store. It depends on bis_pkg.
`default_nettype none
module bis_ctrl
    import bis_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire in_item_t                 item,
    input  wire logic                     descending,
    output logic [IDX_W-1:0]              rd_addr,
    input  wire logic signed [DATA_W-1:0] rd_data,
    output ins_cmd_t                      ins,
    output out_item_t                     result,
    output logic                          result_strobe
);

    bis_state_t               state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     ovf_reg, ovf_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         hi_reg, hi_next;
    logic [IDX_W-1:0]         emit_reg, emit_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic                     last_reg, last_next;
    out_item_t                result_reg, result_next;
    logic                     strobe_reg, strobe_next;

    logic [CNT_W:0]           mid_sum;
    logic [CNT_W-1:0]         mid;
    logic                     goes_before;
    logic                     emit_final;

    assign mid_sum     = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid         = mid_sum[CNT_W:1];
    assign goes_before = descending ? (rd_data < val_reg) : (val_reg < rd_data);
    assign emit_final  = (CNT_W'(emit_reg) + CNT_W'(1)) == count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        emit_reg   <= emit_next;
        val_reg    <= val_next;
        last_reg   <= last_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        emit_next   = emit_reg;
        val_next    = val_reg;
        last_next   = last_reg;
        result_next = result_reg;
        strobe_next = 1'b0;
        ins.en      = 1'b0;
        ins.pos     = lo_reg[IDX_W-1:0];
        ins.value   = val_reg;
        rd_addr     = mid[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    val_next  = item.value;
                    last_next = item.last;
                    lo_next   = '0;
                    hi_next   = count_reg;
                    emit_next = '0;
                    if (count_reg == CNT_W'(MAX_ITEMS))
                    begin
                        ovf_next   = 1'b1;
                        state_next = item.last ? ST_EMIT : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    if (goes_before)
                    begin
                        hi_next = mid;
                    end
                    else
                    begin
                        lo_next = mid + CNT_W'(1);
                    end
                end
                else
                begin
                    ins.en     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    emit_next  = '0;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end

            ST_EMIT:
            begin
                rd_addr                  = emit_reg;
                strobe_next              = 1'b1;
                result_next.sorted_value = rd_data;
                result_next.final_res    = emit_final;
                result_next.overflowed   = ovf_reg;
                if (emit_final)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    emit_next = emit_reg + IDX_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result        = result_reg;
    assign result_strobe = strobe_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("Item count exceeds the store capacity.");

    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEARCH |-> lo_reg <= hi_reg && hi_reg <= count_reg)
        else $error("Search window is out of order.");

    a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(strobe_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("Result beat without an emit cycle.");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && result_reg.final_res |-> count_reg == '0 && !ovf_reg)
        else $error("Set not cleared after its final beat.");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> count_reg != '0)
        else $error("Emit sweep over an empty store.");
`endif

endmodule
`default_nettype wire

// File: sv/binary_insertion_sort_engine.sv
// Top level of the binary insertion sort engine: mode register, sequencer and store.
// It depends on bis_pkg, bis_ctrl and bis_store.
//
//   Channel   Handshake                      Beat
//   item      start, accepted when !busy     value, last
//   result    result_strobe, one cycle       sorted_value, final_res, overflowed
//   cfg       cfg_valid / cfg_ready          descending in bit 0 of cfg_data
//
// An item into a store of n entries keeps busy high through the binary search, one
// comparison per search step, then the shift and insert; a full store drops it with
// no search. A last item then starts an emit sweep over every stored entry, n + 1
// after an insert and n after a drop, one result beat each, each beat registered and
// shown in the cycle after its emit step. Reset empties the set and clears the mode.
// The receiver cannot stall; the mode register is written only while busy is low.
`default_nettype none
module binary_insertion_sort_engine
    import bis_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire in_item_t    item,
    output out_item_t        result,
    output logic             result_strobe,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);

    logic                     descending_reg;
    logic [IDX_W-1:0]         rd_addr;
    logic signed [DATA_W-1:0] rd_data;
    ins_cmd_t                 ins;

    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            descending_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            descending_reg <= cfg_data[0];
        end
    end

    bis_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .descending    (descending_reg),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .ins           (ins),
        .result        (result),
        .result_strobe (result_strobe)
    );

    bis_store u_store (
        .clk     (clk),
        .ins     (ins),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for binary_insertion_sort_engine: a directed table, then random sets.
// It depends on bis_pkg and the engine's RTL; expected beats come from a predictor in this file.
module testbench;
    import bis_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 40;
    localparam int ITEMS_PER_PHASE = 128;
    localparam int PRINT_LIMIT     = 50;
    localparam int RESET_CYCLES    = 9;

    localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    localparam logic MODE_ASCENDING  = 1'b0;
    localparam logic MODE_DESCENDING = 1'b1;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [31:0] cfg_word;
        in_item_t    beat;
        bit          typed;
        out_item_t   want;
    } stim_row_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        start         = 1'b0;
    logic        busy;
    in_item_t    item          = '0;
    out_item_t   result;
    logic        result_strobe;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data      = '0;

    logic signed [DATA_W-1:0] sort_mirror [MAX_ITEMS];
    int        mirror_fill     = 0;
    bit        mirror_overflow = 1'b0;
    bit        mode_desc       = MODE_ASCENDING;
    out_item_t expected_beats [$];
    stim_row_t stim_rows [$];
    int        mismatches      = 0;
    int        quiet_cycles    = 0;
    int        idle_pct        = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    binary_insertion_sort_engine u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result        (result),
        .result_strobe (result_strobe),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (mismatches < PRINT_LIMIT)
        begin
            $display("%0t ns mismatch: %s: got %h, expected %h", $time, what, got, want);
        end
        mismatches++;
    endtask

    function automatic bit precedes(input logic signed [DATA_W-1:0] fresh,
                                    input logic signed [DATA_W-1:0] stored);
        return mode_desc ? (stored < fresh) : (fresh < stored);
    endfunction

    task automatic insort_predict(input in_item_t beat, output int produced);
        int        lo;
        int        hi;
        int        mid;
        int        k;
        out_item_t emitted;
        produced = 0;
        if (mirror_fill >= MAX_ITEMS)
        begin
            mirror_overflow = 1'b1;
        end
        else
        begin
            lo = 0;
            hi = mirror_fill;
            while (lo < hi)
            begin
                mid = (lo + hi) / 2;
                if (precedes(beat.value, sort_mirror[mid]))
                    hi = mid;
                else
                    lo = mid + 1;
            end
            for (k = mirror_fill; k > lo; k--)
                sort_mirror[k] = sort_mirror[k - 1];
            sort_mirror[lo] = beat.value;
            mirror_fill++;
        end
        if (beat.last)
        begin
            for (k = 0; k < mirror_fill; k++)
            begin
                emitted.sorted_value = sort_mirror[k];
                emitted.final_res    = (k == mirror_fill - 1);
                emitted.overflowed   = mirror_overflow;
                expected_beats.push_back(emitted);
            end
            produced        = mirror_fill;
            mirror_fill     = 0;
            mirror_overflow = 1'b0;
        end
    endtask

    task automatic send_item(input in_item_t beat, output int produced);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= beat;
        do @(posedge clk); while (busy);
        insort_predict(beat, produced);
    endtask

    // The mode may change only while the engine is idle, so every expected beat
    // must have arrived and the engine must have finished any insert in flight.
    task automatic write_mode(input logic [31:0] word);
        start <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= word;
        do @(posedge clk); while (!cfg_ready);
        mode_desc = word[0];
        cfg_valid <= 1'b0;
    endtask

    task automatic add_item(input logic signed [DATA_W-1:0] value, input logic last);
        stim_row_t row;
        row            = '{kind: ROW_ITEM, default: '0};
        row.beat.value = value;
        row.beat.last  = last;
        stim_rows.push_back(row);
    endtask

    task automatic add_typed(input logic signed [DATA_W-1:0] value);
        stim_row_t row;
        row            = '{kind: ROW_ITEM, default: '0};
        row.beat.value = value;
        row.beat.last  = 1'b1;
        row.typed      = 1'b1;
        row.want       = '{sorted_value: value, final_res: 1'b1, overflowed: 1'b0};
        stim_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [31:0] word);
        stim_row_t row;
        row          = '{kind: ROW_CFG, default: '0};
        row.cfg_word = word;
        stim_rows.push_back(row);
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_strobe)
        begin
            if (expected_beats.size() == 0)
            begin
                report_mismatch("result beat with nothing expected", result.sorted_value, '0);
            end
            else
            begin
                want = expected_beats.pop_front();
                if (result.sorted_value !== want.sorted_value)
                    report_mismatch("sorted_value", result.sorted_value, want.sorted_value);
                if (result.final_res !== want.final_res)
                    report_mismatch("final_res", DATA_W'(result.final_res),
                                    DATA_W'(want.final_res));
                if (result.overflowed !== want.overflowed)
                    report_mismatch("overflowed", DATA_W'(result.overflowed),
                                    DATA_W'(want.overflowed));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_strobe || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        stim_row_t   row;
        in_item_t    beat;
        logic [31:0] word;
        int          produced;
        int          sent;
        int          phase;
        int          set_size;
        int          style;
        int          split;
        int          k;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_typed(32'sd5);
        add_typed(VALUE_MIN);
        add_typed(VALUE_MAX);
        add_cfg({31'd0, MODE_DESCENDING});
        add_typed(32'sd0);
        add_item(32'sd7, 1'b0);
        add_item(-32'sd3, 1'b0);
        add_item(32'sd7, 1'b0);
        // Upper bits set and bit 0 clear: back to ascending in the middle of a set.
        add_cfg(32'hFFFF_FFFE);
        add_item(32'sd2, 1'b0);
        add_item(32'sd2, 1'b1);
        for (k = 0; k <= MAX_ITEMS; k++)
        begin
            if (k == 3)
                add_item(VALUE_MAX, 1'b0);
            else if (k == 9)
                add_item(VALUE_MIN, 1'b0);
            else
                add_item((k * 7) % 11 - 5, k == MAX_ITEMS);
        end

        idle_pct = 32;
        foreach (stim_rows[i])
        begin
            row = stim_rows[i];
            if (row.kind == ROW_CFG)
            begin
                write_mode(row.cfg_word);
            end
            else
            begin
                send_item(row.beat, produced);
                if (row.typed)
                begin
                    repeat (produced) void'(expected_beats.pop_back());
                    expected_beats.push_back(row.want);
                end
            end
        end

        sent = 0;
        for (phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 32 : (phase == 1) ? 74 : 0;
            word     = $urandom();
            word[0]  = phase[0];
            write_mode(word);
            while (sent < (phase + 1) * ITEMS_PER_PHASE)
            begin
                if ($urandom_range(9) == 0)
                    set_size = $urandom_range(MAX_ITEMS + 5, MAX_ITEMS + 1);
                else
                    set_size = $urandom_range(MAX_ITEMS, 1);
                style = $urandom_range(3);
                split = ($urandom_range(14) == 0) ? $urandom_range(set_size - 1, 0) : 0;
                for (k = 0; k < set_size; k++)
                begin
                    if (split != 0 && k == split)
                        write_mode($urandom());
                    case (style)
                        0: beat.value = $urandom();
                        1: beat.value = $signed($urandom_range(6)) - 3;
                        2:
                        begin
                            case ($urandom_range(3))
                                0: beat.value = VALUE_MIN;
                                1: beat.value = VALUE_MAX;
                                2: beat.value = 32'sd0;
                                default: beat.value = -32'sd1;
                            endcase
                        end
                        default: beat.value = $signed($urandom()) >>> $urandom_range(31);
                    endcase
                    beat.last = (k == set_size - 1);
                    send_item(beat, produced);
                    sent++;
                end
                if ($urandom_range(6) == 0)
                    write_mode($urandom());
            end
        end

        start <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
